// File: rtl/core/pdv_pkg.sv
package pdv_pkg;

  // Byte positions within a frame, counted from the first start-of-frame byte
  localparam int unsigned PosW = 17;
  localparam logic [PosW-1:0] POS_HUNT        = 17'd0;
  localparam logic [PosW-1:0] POS_SOF_SECOND  = 17'd1;
  localparam logic [PosW-1:0] POS_LIMIT_FIRST = 17'd10;
  localparam logic [PosW-1:0] POS_IDS_FIRST   = 17'd14;
  localparam logic [PosW-1:0] POS_LEN_FIRST   = 17'd17;
  localparam logic [PosW-1:0] POS_LEN_LAST    = 17'd18;
  localparam logic [PosW-1:0] POS_PAYLOAD     = 17'd19;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  // Frame end status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_SUM  = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_SOF_HIGH    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SOF_LOW     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PAYLOAD = 2'd2;
  localparam int unsigned CfgDataW = 16;

  // Width of the packed result data bus, rounded up to whole bytes
  localparam int unsigned ResBits = 162;
  localparam int unsigned OutDataW = ((ResBits + 7) / 8) * 8;

  // One result item
  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [63:0] time_stamp;
    logic [31:0] time_limit;
    logic [7:0]  src_addr;
    logic [7:0]  dst_addr;
    logic [7:0]  frame_kind;
    logic [15:0] body_len;
    logic [1:0]  status;
    logic        last;
  } res_t;

  // Handshake between the deframer and the output stage
  typedef struct packed {
    logic valid;
    res_t res;
  } res_xfer_t;

endpackage

// File: rtl/core/packet_deframe_validate_core.sv
// Channel | Dir | Ports                              | Contents
// in      | in  | in_tvalid/in_tready/in_tdata[7:0]  | rx_byte
// out     | out | out_tvalid/out_tready/out_tdata    | header, payload byte, status
//         |     | out_tuser, out_tlast               | kind, last
// cfg     | in  | cfg_we/cfg_index/cfg_wdata         | sof_high, sof_low, max_payload
//
// One byte is taken per cycle unless a stall on out_tready holds the walk; a byte
// goes to the input register, its result to the output register, whence it can leave.
// The frame walk between the two registers is combinational.
// rst_n is synchronous: the block returns to hunting with default registers.
// A stall on out_tready holds the walk; in_tready drops once the input
// register is full and cannot advance.
module packet_deframe_validate_core
  import pdv_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,    // [7:0] rx_byte
  output logic                out_tvalid,
  input  logic                out_tready,
  // [7:0] data_byte, [23:8] byte_index, [87:24] time_stamp, [119:88] time_limit,
  // [127:120] src_addr, [135:128] dst_addr, [143:136] frame_kind,
  // [159:144] body_len, [161:160] status, [167:162] zero
  output logic [OutDataW-1:0] out_tdata,
  output logic                out_tuser,   // [0] kind
  output logic                out_tlast,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  logic      in_vld_r;
  logic [7:0] in_byte_r;
  logic      space;
  logic      step;
  res_xfer_t res;

  // Input register advances whenever the output slot can take the result
  assign step      = in_vld_r && space;
  assign in_tready = !in_vld_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  pdv_deframer u_deframer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .rx_byte   (in_byte_r),
    .res_o     (res)
  );

  pdv_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_i      (res),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: rtl/core/pdv_deframer.sv
module pdv_deframer
  import pdv_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  output res_xfer_t           res_o
);

  logic [7:0]      sof_high_r, sof_low_r;
  logic [15:0]     max_payload_r;

  logic [PosW-1:0] pos_r, pos_nxt;
  logic [15:0]     len_r, len_nxt;
  logic [7:0]      sum1_r, sum1_nxt, sum2_r, sum2_nxt;
  logic [63:0]     stamp_r, stamp_nxt;
  logic [31:0]     limit_r, limit_nxt;
  logic [23:0]     ids_r, ids_nxt;
  logic [7:0]      hold_r, hold_nxt;

  logic [7:0]      fold1, fold2;
  logic [PosW-1:0] pos_inc, pay_end;
  logic [15:0]     len_shift;

  // Fletcher-style fold (plain modulo-256 sums) of the current byte, and derived positions
  assign fold1     = sum1_r + rx_byte;
  assign fold2     = sum2_r + fold1;
  assign pos_inc   = pos_r + 1'b1;
  assign pay_end   = POS_PAYLOAD + {1'b0, len_r};
  assign len_shift = {len_r[7:0], rx_byte};

  // Per-byte frame walk
  always_comb begin
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    sum1_nxt  = sum1_r;
    sum2_nxt  = sum2_r;
    stamp_nxt = stamp_r;
    limit_nxt = limit_r;
    ids_nxt   = ids_r;
    hold_nxt  = hold_r;
    res_o     = '0;
    if (step) begin
      if (pos_r == POS_HUNT) begin
        if (rx_byte == sof_high_r) begin
          sum1_nxt = rx_byte;
          sum2_nxt = rx_byte;
          pos_nxt  = POS_SOF_SECOND;
        end
      end else if (pos_r == POS_SOF_SECOND) begin
        if (rx_byte == sof_low_r) begin
          sum1_nxt = fold1;
          sum2_nxt = fold2;
          pos_nxt  = pos_inc;
        end else if (rx_byte == sof_high_r) begin
          // repeated first byte restarts the frame here
          sum1_nxt = rx_byte;
          sum2_nxt = rx_byte;
        end else begin
          pos_nxt = POS_HUNT;
        end
      end else if (pos_r < POS_PAYLOAD) begin
        // header bytes, big-endian
        sum1_nxt = fold1;
        sum2_nxt = fold2;
        pos_nxt  = pos_inc;
        if (pos_r < POS_LIMIT_FIRST) begin
          stamp_nxt = {stamp_r[55:0], rx_byte};
        end else if (pos_r < POS_IDS_FIRST) begin
          limit_nxt = {limit_r[23:0], rx_byte};
        end else if (pos_r < POS_LEN_FIRST) begin
          ids_nxt = {ids_r[15:0], rx_byte};
        end else begin
          len_nxt = len_shift;
        end
        // oversize frame: report and drop
        if (pos_r == POS_LEN_LAST && len_shift > max_payload_r) begin
          pos_nxt              = POS_HUNT;
          res_o.valid          = 1'b1;
          res_o.res.kind       = KIND_END;
          res_o.res.time_stamp = stamp_r;
          res_o.res.time_limit = limit_r;
          res_o.res.src_addr   = ids_r[23:16];
          res_o.res.dst_addr   = ids_r[15:8];
          res_o.res.frame_kind = ids_r[7:0];
          res_o.res.body_len   = len_shift;
          res_o.res.status     = STATUS_TOO_LONG;
          res_o.res.last       = 1'b1;
        end
      end else if (pos_r < pay_end) begin
        // payload byte
        sum1_nxt             = fold1;
        sum2_nxt             = fold2;
        pos_nxt              = pos_inc;
        res_o.valid          = 1'b1;
        res_o.res.kind       = KIND_PAYLOAD;
        res_o.res.data_byte  = rx_byte;
        res_o.res.byte_index = 16'(pos_r - POS_PAYLOAD);
      end else if (pos_r == pay_end) begin
        hold_nxt = rx_byte;
        pos_nxt  = pos_inc;
      end else begin
        // second checksum byte closes the frame
        pos_nxt              = POS_HUNT;
        res_o.valid          = 1'b1;
        res_o.res.kind       = KIND_END;
        res_o.res.time_stamp = stamp_r;
        res_o.res.time_limit = limit_r;
        res_o.res.src_addr   = ids_r[23:16];
        res_o.res.dst_addr   = ids_r[15:8];
        res_o.res.frame_kind = ids_r[7:0];
        res_o.res.body_len   = len_r;
        res_o.res.status     = (hold_r == sum1_r && rx_byte == sum2_r) ?
                               STATUS_OK : STATUS_BAD_SUM;
        res_o.res.last       = 1'b1;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sof_high_r    <= '0;
      sof_low_r     <= '0;
      max_payload_r <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SOF_HIGH:    sof_high_r    <= cfg_wdata[7:0];
        CFG_SOF_LOW:     sof_low_r     <= cfg_wdata[7:0];
        CFG_MAX_PAYLOAD: max_payload_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_HUNT;
      len_r   <= '0;
      sum1_r  <= '0;
      sum2_r  <= '0;
      stamp_r <= '0;
      limit_r <= '0;
      ids_r   <= '0;
      hold_r  <= '0;
    end else begin
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      sum1_r  <= sum1_nxt;
      sum2_r  <= sum2_nxt;
      stamp_r <= stamp_nxt;
      limit_r <= limit_nxt;
      ids_r   <= ids_nxt;
      hold_r  <= hold_nxt;
    end
  end

endmodule

// File: rtl/core/pdv_out_reg.sv
module pdv_out_reg
  import pdv_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  res_xfer_t           res_i,
  output logic                space,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,
  output logic                out_tuser,
  output logic                out_tlast
);

  logic valid_r;
  res_t res_r;

  // Slot is free when empty or being drained this cycle
  assign space = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (space) begin
      valid_r <= res_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (space && res_i.valid) begin
      res_r <= res_i.res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.last;
  assign out_tdata  = {(OutDataW - ResBits)'(0), res_r.status, res_r.body_len,
                       res_r.frame_kind, res_r.dst_addr, res_r.src_addr,
                       res_r.time_limit, res_r.time_stamp, res_r.byte_index,
                       res_r.data_byte};

endmodule

// File: tb/sv/pdv_result_checker.sv
`timescale 1ns / 100ps

// Watches the byte input, result output and register write port of the
// deframer, runs its own frame walk on every accepted byte and compares each
// result transfer against the oldest predicted result.
module pdv_result_checker
  import pdv_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OutDataW-1:0] out_tdata,
  input  logic                out_tuser,
  input  logic                out_tlast,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output int                  mismatch_count,
  output int                  results_due,
  output int                  results_checked
);

  // Bits of tdata that carry result fields; everything above is zero fill
  localparam int unsigned TdataBits = 162;

  // Register copies
  logic [7:0]  sof_hi_q;
  logic [7:0]  sof_lo_q;
  logic [15:0] len_cap_q;

  // Frame walk state
  logic [PosW-1:0] walk_pos;
  logic [15:0]     frame_len;
  logic [7:0]      sum_a;
  logic [7:0]      sum_b;
  logic [63:0]     stamp_q;
  logic [31:0]     limit_q;
  logic [23:0]     ids_q;
  logic [7:0]      sum_hold;

  // Results predicted but not yet seen on the output
  res_t due_results[$];

  // Fletcher-style pair update, plain modulo-256 sums
  task automatic add_to_sum(input logic [7:0] b);
    sum_a = sum_a + b;
    sum_b = sum_b + sum_a;
  endtask

  function automatic res_t frame_end_record(input logic [1:0] st);
    res_t r;
    r            = '0;
    r.kind       = KIND_END;
    r.time_stamp = stamp_q;
    r.time_limit = limit_q;
    r.src_addr   = ids_q[23:16];
    r.dst_addr   = ids_q[15:8];
    r.frame_kind = ids_q[7:0];
    r.body_len   = frame_len;
    r.status     = st;
    r.last       = 1'b1;
    return r;
  endfunction

  // Advance the frame walk by one received byte
  task automatic walk_frame_byte(input logic [7:0] b);
    res_t r;
    r = '0;
    if (walk_pos == POS_HUNT) begin
      if (b == sof_hi_q) begin
        sum_a = '0;
        sum_b = '0;
        add_to_sum(b);
        walk_pos = POS_SOF_SECOND;
      end
    end else if (walk_pos == POS_SOF_SECOND) begin
      if (b == sof_lo_q) begin
        add_to_sum(b);
        walk_pos = POS_SOF_SECOND + 1'b1;
      end else if (b == sof_hi_q) begin
        // repeated first byte restarts the frame
        sum_a = '0;
        sum_b = '0;
        add_to_sum(b);
      end else begin
        walk_pos = POS_HUNT;
      end
    end else if (walk_pos < POS_PAYLOAD) begin
      // big-endian header shift
      add_to_sum(b);
      if (walk_pos < POS_LIMIT_FIRST) stamp_q = {stamp_q[55:0], b};
      else if (walk_pos < POS_IDS_FIRST) limit_q = {limit_q[23:0], b};
      else if (walk_pos < POS_LEN_FIRST) ids_q = {ids_q[15:0], b};
      else frame_len = {frame_len[7:0], b};
      walk_pos = walk_pos + 1'b1;
      if (walk_pos == POS_PAYLOAD && frame_len > len_cap_q) begin
        due_results.insert(due_results.size(), frame_end_record(STATUS_TOO_LONG));
        walk_pos = POS_HUNT;
      end
    end else if (walk_pos < POS_PAYLOAD + frame_len) begin
      add_to_sum(b);
      r.kind       = KIND_PAYLOAD;
      r.data_byte  = b;
      r.byte_index = walk_pos[15:0] - POS_PAYLOAD[15:0];
      due_results.insert(due_results.size(), r);
      walk_pos = walk_pos + 1'b1;
    end else if (walk_pos == POS_PAYLOAD + frame_len) begin
      sum_hold = b;
      walk_pos = walk_pos + 1'b1;
    end else begin
      due_results.insert(due_results.size(), frame_end_record(
        (sum_hold == sum_a && b == sum_b) ? STATUS_OK : STATUS_BAD_SUM));
      walk_pos = POS_HUNT;
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // Compare one result transfer with the oldest prediction
  task automatic check_result_transfer();
    res_t e;
    if (due_results.size() == 0) begin
      $error("result transfer with nothing predicted: tuser %b tlast %b tdata %h",
             out_tuser, out_tlast, out_tdata);
      mismatch_count++;
      return;
    end
    e = due_results.pop_front();
    results_checked++;
    check_field("kind", 64'(e.kind), 64'(out_tuser));
    check_field("data_byte", 64'(e.data_byte), 64'(out_tdata[7:0]));
    check_field("byte_index", 64'(e.byte_index), 64'(out_tdata[23:8]));
    check_field("time_stamp", e.time_stamp, out_tdata[87:24]);
    check_field("time_limit", 64'(e.time_limit), 64'(out_tdata[119:88]));
    check_field("src_addr", 64'(e.src_addr), 64'(out_tdata[127:120]));
    check_field("dst_addr", 64'(e.dst_addr), 64'(out_tdata[135:128]));
    check_field("frame_kind", 64'(e.frame_kind), 64'(out_tdata[143:136]));
    check_field("body_len", 64'(e.body_len), 64'(out_tdata[159:144]));
    check_field("status", 64'(e.status), 64'(out_tdata[161:160]));
    check_field("tdata zero fill", '0, 64'(out_tdata[OutDataW-1:TdataBits]));
    check_field("last", 64'(e.last), 64'(out_tlast));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sof_hi_q        = '0;
      sof_lo_q        = '0;
      len_cap_q       = 16'hFFFF;
      walk_pos        = POS_HUNT;
      frame_len       = '0;
      sum_a           = '0;
      sum_b           = '0;
      stamp_q         = '0;
      limit_q         = '0;
      ids_q           = '0;
      sum_hold        = '0;
      mismatch_count  = 0;
      results_checked = 0;
      due_results.delete();
    end else begin
      // output first: a result never belongs to a byte taken at the same edge
      if (out_tvalid && out_tready) check_result_transfer();
      if (in_tvalid && in_tready) walk_frame_byte(in_tdata);
      if (cfg_we) begin
        case (cfg_index)
          CFG_SOF_HIGH:    sof_hi_q = cfg_wdata[7:0];
          CFG_SOF_LOW:     sof_lo_q = cfg_wdata[7:0];
          CFG_MAX_PAYLOAD: len_cap_q = cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
    results_due = due_results.size();
  end

endmodule

// File: tb/sv/packet_deframe_validate_core_tb.sv
`timescale 1ns / 100ps

module packet_deframe_validate_core_tb;
  import pdv_pkg::*;

  localparam int MaxCycles    = 400000;
  localparam int PhaseBytes   = 410;
  localparam int SettleCycles = 6;

  typedef enum {
    FRAME_GOOD,
    FRAME_BAD_SUM,
    FRAME_TOO_LONG,
    FRAME_CUT
  } frame_mode_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tuser;
  logic                out_tlast;
  logic                cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index  = CFG_SOF_HIGH;
  logic [CfgDataW-1:0] cfg_wdata  = '0;

  int mismatch_count;
  int results_due;
  int results_checked;

  // Flow-control knobs, percent of cycles
  int sender_idle_pct = 0;
  int stall_pct       = 0;

  int cycle_count = 0;
  int bytes_sent  = 0;
  int frames_sent = 0;
  int n_settings  = 0;

  // Register values currently in the block, used to build frames
  logic [7:0]  sof_hi  = '0;
  logic [7:0]  sof_lo  = '0;
  logic [15:0] max_len = 16'hFFFF;

  packet_deframe_validate_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  pdv_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .results_due     (results_due),
    .results_checked (results_checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver backpressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == MaxCycles) begin
      $display("Timeout after %0d cycles, %0d results still due", cycle_count, results_due);
      $display("Test completed with failures");
      $finish;
    end
  end

  // One byte transfer, with random sender gaps; starts and ends at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Stop sending and wait until every predicted result has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [7:0] hi, input logic [7:0] lo,
                               input logic [15:0] len_cap);
    drain();
    write_reg(CFG_SOF_HIGH, {8'h00, hi});
    write_reg(CFG_SOF_LOW, {8'h00, lo});
    write_reg(CFG_MAX_PAYLOAD, len_cap);
    sof_hi  = hi;
    sof_lo  = lo;
    max_len = len_cap;
    n_settings++;
  endtask

  // Random byte that can never open a frame
  function automatic logic [7:0] stray_byte();
    logic [7:0] x;
    x = 8'($urandom_range(255));
    while (x == sof_hi || x == sof_lo) x = x + 8'd1;
    return x;
  endfunction

  // Build and send one frame; a too-long frame is followed by up to eight stray bytes
  task automatic send_frame(input logic [15:0] pay_len, input frame_mode_t mode,
                            input logic [63:0] stamp, input logic [31:0] limit,
                            input logic [23:0] ids, input bit plant_sof);
    logic [7:0] fb[$];
    logic [7:0] s1;
    logic [7:0] s2;
    int i;
    int keep;
    fb = {};
    fb.insert(fb.size(), sof_hi);
    fb.insert(fb.size(), sof_lo);
    for (i = 7; i >= 0; i--) fb.insert(fb.size(), stamp[i*8 +: 8]);
    for (i = 3; i >= 0; i--) fb.insert(fb.size(), limit[i*8 +: 8]);
    for (i = 2; i >= 0; i--) fb.insert(fb.size(), ids[i*8 +: 8]);
    fb.insert(fb.size(), pay_len[15:8]);
    fb.insert(fb.size(), pay_len[7:0]);
    if (mode == FRAME_TOO_LONG) begin
      keep = $urandom_range(8);
      for (i = 0; i < keep; i++) fb.insert(fb.size(), stray_byte());
    end else begin
      for (i = 0; i < pay_len; i++) fb.insert(fb.size(), 8'($urandom_range(255)));
      // start pattern inside the payload
      if (plant_sof && pay_len >= 2) begin
        fb[19] = sof_hi;
        fb[20] = sof_lo;
      end
      s1 = '0;
      s2 = '0;
      foreach (fb[k]) begin
        s1 = s1 + fb[k];
        s2 = s2 + s1;
      end
      if (mode == FRAME_BAD_SUM) begin
        if ($urandom_range(1)) s1 = s1 ^ 8'(1 << $urandom_range(7));
        else s2 = s2 ^ 8'(1 << $urandom_range(7));
      end
      fb.insert(fb.size(), s1);
      fb.insert(fb.size(), s2);
      if (mode == FRAME_CUT) begin
        keep = $urandom_range(fb.size() - 1, 1);
        while (fb.size() > keep) void'(fb.pop_back());
      end
    end
    foreach (fb[k]) send_byte(fb[k]);
    frames_sent++;
  endtask

  // Random traffic: mostly valid frames, plus broken frames and stray bytes
  task automatic run_phase(input int idle_pct, input int stall, input int n_bytes);
    int stop_at;
    int pause_at;
    int pick;
    int lim;
    int pay_len;
    int too_long;
    bit paused;
    logic [63:0] stamp;
    logic [31:0] limit;
    logic [23:0] ids;
    sender_idle_pct = idle_pct;
    stall_pct       = stall;
    stop_at  = bytes_sent + n_bytes;
    pause_at = bytes_sent + n_bytes / 2;
    paused   = 1'b0;
    while (bytes_sent < stop_at) begin
      // hold off mid-phase until the output has caught up
      if (!paused && bytes_sent >= pause_at) begin
        drain();
        paused = 1'b1;
      end
      stamp = {$urandom, $urandom};
      limit = $urandom;
      ids   = 24'($urandom);
      lim = (max_len < 12) ? int'(max_len) : 12;
      if ($urandom_range(9) == 0) lim = (max_len < 60) ? int'(max_len) : 60;
      pay_len = $urandom_range(lim, 0);
      too_long = ($urandom_range(3) == 0) ? int'(max_len) + 1 :
                 $urandom_range(65535, int'(max_len) + 1);
      pick = $urandom_range(99);
      // no too-long frames at the top cap; no cut frames where a misread length is huge
      if (pick >= 72 && pick < 80 && max_len == 16'hFFFF) pick = 0;
      if (pick >= 80 && pick < 83 && max_len > 255) pick = 0;
      if (pick < 62) begin
        send_frame(16'(pay_len), FRAME_GOOD, stamp, limit, ids, 1'b0);
      end else if (pick < 72) begin
        send_frame(16'(pay_len), FRAME_BAD_SUM, stamp, limit, ids, $urandom_range(3) == 0);
      end else if (pick < 80) begin
        send_frame(16'(too_long), FRAME_TOO_LONG, stamp, limit, ids, 1'b0);
      end else if (pick < 83) begin
        send_frame(16'(pay_len), FRAME_CUT, stamp, limit, ids, 1'b0);
      end else if (pick < 93) begin
        repeat ($urandom_range(6, 1)) send_byte(stray_byte());
      end else begin
        // broken start: lone first byte, optionally followed by a wrong second byte
        send_byte(sof_hi);
        if ($urandom_range(1)) send_byte(stray_byte());
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames
    apply_setting(8'hA5, 8'h5A, 16'd64);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'hA5);
    send_byte(8'h11);
    send_byte(8'hA5);
    send_frame(16'd0, FRAME_GOOD, '1, '0, 24'h00FFA5, 1'b0);
    send_frame(16'd5, FRAME_GOOD, '0, '1, 24'hFF00FF, 1'b0);
    send_frame(16'd6, FRAME_BAD_SUM, 64'h0123_4567_89AB_CDEF, 32'h8000_0001,
               24'h010203, 1'b1);
    send_frame(16'd3, FRAME_GOOD, 64'hFEDC_BA98_7654_3210, 32'h7FFF_FFFE,
               24'h807F01, 1'b0);
    send_frame(16'hFFFF, FRAME_TOO_LONG, '1, '1, '1, 1'b0);
    send_frame(16'd64, FRAME_GOOD, 64'h5555_AAAA_5555_AAAA, 32'hAAAA_5555,
               24'h55AA55, 1'b0);
    send_frame(16'd65, FRAME_TOO_LONG, '0, '0, '0, 1'b0);
    // equal start bytes, zero cap
    apply_setting(8'h00, 8'h00, 16'd0);
    send_frame(16'd1, FRAME_TOO_LONG, 64'h1, 32'h2, 24'h3, 1'b0);
    send_frame(16'd0, FRAME_GOOD, '0, '0, '0, 1'b0);

    // Random phases
    apply_setting(8'h7E, 8'h81, 16'd40);
    run_phase(0, 0, PhaseBytes);
    apply_setting(8'hFF, 8'h00, 16'hFFFF);
    run_phase(46, 0, PhaseBytes);
    apply_setting(8'($urandom_range(255)), 8'($urandom_range(255)),
                  16'($urandom_range(48, 8)));
    run_phase(0, 46, PhaseBytes);
    apply_setting(8'h3C, 8'h3C, 16'd24);
    run_phase(21, 21, PhaseBytes);

    drain();
    repeat (10) @(negedge clk);

    $display("Run covered %0d stream bytes in %0d generated frames under %0d register settings",
             bytes_sent, frames_sent, n_settings);
    $display("%0d result transfers compared across four flow-control phases",
             results_checked);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
